/* sv/agis_pkg.sv */
// Package with shared types, field constants and GF(2^8) table generators for the S-box.
package agis_pkg;

  localparam int BYTE_W = 8;
  localparam int MAT_W = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // Reduction polynomial x^8+x^4+x^3+x+1 and the order of the multiplicative group.
  localparam logic [8:0] GF_POLY = 9'h11B;
  localparam logic [7:0] GF_ORDER = 8'd255;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_IN_MATRIX = 2'd0;
  localparam logic [1:0] REG_OUT_MATRIX = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;
  localparam logic [1:0] REG_OUT_CONST = 2'd3;

  typedef logic [255:0][7:0] gf_tbl_t;

  typedef struct packed {
    logic [MAT_W-1:0]  in_matrix;
    logic [MAT_W-1:0]  out_matrix;
    logic [BYTE_W-1:0] seed;
    logic [BYTE_W-1:0] out_const;
  } cfg_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
  endfunction

  // Powers of the generator x+1, evaluated at elaboration.
  function automatic gf_tbl_t gen_exp_tbl();
    gf_tbl_t t;
    logic [7:0] a;
    t = '0;
    a = 8'h01;
    for (int i = 0; i < 256; i++) begin
      t[i] = a;
      a = a ^ xtime(a);
    end
    return t;
  endfunction

  function automatic gf_tbl_t gen_log_tbl();
    gf_tbl_t t;
    logic [7:0] a;
    t = '0;
    a = 8'h01;
    for (int i = 0; i < 255; i++) begin
      t[a] = 8'(i);
      a = a ^ xtime(a);
    end
    return t;
  endfunction

  localparam gf_tbl_t EXP_TBL = gen_exp_tbl();
  localparam gf_tbl_t LOG_TBL = gen_log_tbl();

  // Matrix over GF(2) with each diagonal bit forced set, then a constant XOR.
  function automatic logic [7:0] affine(input logic [MAT_W-1:0] rows, input logic [7:0] v,
                                        input logic [7:0] c);
    logic [7:0] r;
    logic [7:0] row;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      row = rows[8*k +: 8] | (8'h01 << k);
      r[k] = ^(row & v);
    end
    return r ^ c;
  endfunction

endpackage

/* sv/agis_cfg.sv */
// Configuration register file behind the APB-style port.
module agis_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [agis_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [agis_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [agis_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output agis_pkg::cfg_t                      cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[agis_pkg::CFG_ADDR_W-1:3];
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        agis_pkg::REG_IN_MATRIX: cfg.in_matrix <= pwdata;
        agis_pkg::REG_OUT_MATRIX: cfg.out_matrix <= pwdata;
        agis_pkg::REG_SEED: cfg.seed <= pwdata[agis_pkg::BYTE_W-1:0];
        agis_pkg::REG_OUT_CONST: cfg.out_const <= pwdata[agis_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      agis_pkg::REG_IN_MATRIX: prdata = cfg.in_matrix;
      agis_pkg::REG_OUT_MATRIX: prdata = cfg.out_matrix;
      agis_pkg::REG_SEED: prdata = {56'd0, cfg.seed};
      agis_pkg::REG_OUT_CONST: prdata = {56'd0, cfg.out_const};
      default: prdata = '0;
    endcase
  end

endmodule

/* sv/agis_affine.sv */
// One registered affine stage: GF(2) matrix with forced diagonal, then a constant XOR.
module agis_affine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [agis_pkg::BYTE_W-1:0]     in_data,
  input  logic [agis_pkg::MAT_W-1:0]      rows,
  input  logic [agis_pkg::BYTE_W-1:0]     cnst,
  output logic                            out_valid,
  output logic [agis_pkg::BYTE_W-1:0]     out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= agis_pkg::affine(rows, in_data, cnst);
  end

endmodule

/* sv/agis_inv.sv */
// Two-stage GF(2^8) inverter: logarithm lookup, then exponent of the negated logarithm.
module agis_inv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [agis_pkg::BYTE_W-1:0]     in_data,
  output logic                            out_valid,
  output logic [agis_pkg::BYTE_W-1:0]     out_data
);

  logic                          log_valid;
  logic [agis_pkg::BYTE_W-1:0]   log_val;
  logic                          log_zero;
  logic [agis_pkg::BYTE_W-1:0]   exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      log_valid <= in_valid;
      out_valid <= log_valid;
    end
  end

  always_ff @(posedge clk) begin
    log_val <= agis_pkg::LOG_TBL[in_data];
    log_zero <= (in_data == '0);
  end

  // The inverse of (x+1)^l is (x+1)^(255-l); a logarithm of zero wraps to index zero.
  assign exp_idx = (log_val == '0) ? '0 : agis_pkg::GF_ORDER - log_val;

  always_ff @(posedge clk) begin
    out_data <= log_zero ? '0 : agis_pkg::EXP_TBL[exp_idx];
  end

endmodule

/* sv/affine_gf256_inverse_sbox_top.sv */
// A byte taken with start appears on out_byte with done once it has passed every stage.
// Throughput: one byte per cycle; busy is always low and every stage is a register.
// The stages are input affine map, log lookup, exp lookup, and output affine map.
// Results cannot be stalled: each sits on out_byte for exactly one cycle.
// Reset clears the pipeline valid bits and all configuration registers to zero.
module affine_gf256_inverse_sbox_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [agis_pkg::BYTE_W-1:0]         in_byte,
  output logic                                done,
  output logic [agis_pkg::BYTE_W-1:0]         out_byte,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [agis_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [agis_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [agis_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  agis_pkg::cfg_t                cfg;
  logic                          s1_valid;
  logic [agis_pkg::BYTE_W-1:0]   s1_data;
  logic                          s3_valid;
  logic [agis_pkg::BYTE_W-1:0]   s3_data;
  logic                          in_xfer;

  assign busy = 1'b0;
  assign in_xfer = start & ~busy;

  agis_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  agis_affine u_aff_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_xfer),
    .in_data   (in_byte),
    .rows      (cfg.in_matrix),
    .cnst      (cfg.seed),
    .out_valid (s1_valid),
    .out_data  (s1_data)
  );

  agis_inv u_inv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_valid (s3_valid),
    .out_data  (s3_data)
  );

  agis_affine u_aff_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_data   (s3_data),
    .rows      (cfg.out_matrix),
    .cnst      (cfg.out_const),
    .out_valid (done),
    .out_data  (out_byte)
  );

endmodule
